// ----- src/art_pkg.sv -----
// Shared types and constants for the address range table.
// Used by art_ctrl, art_dp and address_range_table_core; depends on nothing.
package art_pkg;

    // Field widths of one range entry and of the result fields.
    localparam int ADDR_W   = 16;
    localparam int ENTRY_W  = 2 * ADDR_W;
    localparam int STATUS_W = 2;
    localparam int RIDX_W   = 4;
    localparam int RCNT_W   = 5;

    // An address this close to a range edge extends the range.
    localparam int EDGE_REACH = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_FIND   = 2'd1,
        OP_MERGE  = 2'd2
    } op_t;

    // Micro-operations that the controller issues to the datapath, one per cycle.
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_START,
        CMD_I_INC,
        CMD_RD_I,
        CMD_APP_EXT_HI,
        CMD_APP_EXT_LO,
        CMD_APP_NEW,
        CMD_APP_INS,
        CMD_SHIFT_UP_INIT,
        CMD_RD_JM1,
        CMD_WR_J_DEC,
        CMD_RES_HIT,
        CMD_RES_FULL,
        CMD_RES_MISS,
        CMD_RES_EMPTY,
        CMD_MRG_LOAD,
        CMD_RD_I1,
        CMD_MRG_JOIN,
        CMD_MRG_ADV,
        CMD_RD_JP1,
        CMD_WR_J_INC,
        CMD_PUSH
    } dp_cmd_t;

    // Status flags that the datapath reports back to the controller.
    typedef struct packed {
        op_t  op;
        logic i_at_n;
        logic full;
        logic above;
        logic ext_hi;
        logic ins;
        logic ext_lo;
        logic hit;
        logic i1_lt_n;
        logic j_at_i;
        logic j_at_n;
        logic mergeable;
        logic out_free;
    } dp_flags_t;

endpackage

// ----- src/address_range_table_core.sv -----
// Top level of the address range table: stream ports, controller and datapath.
// Depends on art_pkg, art_ctrl, art_dp and art_ram.
//
// Keeps a sorted table of up to MAX_RANGES address ranges in a one-read,
// one-write RAM and answers one result item for every input item. The block
// works on one item at a time: it starts the item, reads and then examines
// table entries one by one, moves each entry with a read and then a write,
// and hands the result over. A merge that has a pair to examine first loads
// its first range and writes each join into the table. An append that inserts
// in front of entry i moves count-i entries; a merge examines each neighbor
// pair once and, for every join, moves all ranges above it. This pace comes
// from the single read port of the table RAM and its registered read. A new
// item is accepted as soon as its predecessor's result sits in the output
// register, even if that result is not yet taken. merge_gap is written through
// cfg_we/cfg_wdata; the user must write it only while no item is in flight,
// which the block itself does not enforce.
module address_range_table_core
    import art_pkg::*;
#(
    parameter int MAX_RANGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[1:0], address[17:2], zero[23:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], range_index[5:2], range_start[21:6],
                                   // range_end[37:22], range_count[42:38], zero[47:43]
);

    dp_cmd_t             cmd;
    dp_flags_t           flags;
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   range_index;
    logic [ADDR_W-1:0]   range_start, range_end;
    logic [RCNT_W-1:0]   range_count;

    art_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    art_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .flags      (flags),
        .in_op      (s_tdata[1:0]),
        .in_addr    (s_tdata[17:2]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status),
        .out_index  (range_index),
        .out_start  (range_start),
        .out_end    (range_end),
        .out_count  (range_count)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_tdata = {5'b0, range_count, range_end, range_start, range_index, status};

endmodule

// ----- src/art_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the range entries of the table.
module art_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/art_dp.sv -----
// Datapath of the address range table: table memory, counters, compares and result register.
// Depends on art_pkg and art_ram; driven by commands from art_ctrl.
module art_dp
    import art_pkg::*;
#(
    parameter int MAX_RANGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_flags_t           flags,
    input  logic [1:0]          in_op,
    input  logic [ADDR_W-1:0]   in_addr,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [RIDX_W-1:0]   out_index,
    output logic [ADDR_W-1:0]   out_start,
    output logic [ADDR_W-1:0]   out_end,
    output logic [RCNT_W-1:0]   out_count
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    // Item and control registers.
    op_t                 op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   gap_reg;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [ADDR_W-1:0]   cur_lo_reg, cur_hi_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [IW-1:0]       res_idx_reg;
    logic [ADDR_W-1:0]   res_lo_reg, res_hi_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [RIDX_W-1:0]   out_index_reg;
    logic [ADDR_W-1:0]   out_start_reg, out_end_reg;
    logic [RCNT_W-1:0]   out_count_reg;

    // Memory port signals.
    logic                ram_we, ram_re;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [ADDR_W-1:0]   rd_lo, rd_hi;

    // Derived indexes and values.
    logic [CW:0]         i_plus1, j_plus1;
    logic [CW-1:0]       j_minus1;
    logic [ADDR_W-1:0]   join_hi;
    logic [IW+RIDX_W-1:0] res_idx_wide;
    logic [CW+RCNT_W-1:0] count_wide;

    art_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_lo    = ram_rdata[ENTRY_W-1:ADDR_W];
    assign rd_hi    = ram_rdata[ADDR_W-1:0];
    assign i_plus1  = {1'b0, i_reg} + 1'b1;
    assign j_plus1  = {1'b0, j_reg} + 1'b1;
    assign j_minus1 = j_reg - 1'b1;
    assign join_hi  = (cur_hi_reg < rd_hi) ? rd_hi : cur_hi_reg;

    // Status flags for the controller.
    always_comb
    begin
        flags.op        = op_reg;
        flags.i_at_n    = (i_reg == n_reg);
        flags.full      = (n_reg == CW'(MAX_RANGES));
        flags.above     = ({1'b0, addr_reg} > ({1'b0, rd_hi} + 17'(EDGE_REACH)));
        flags.ext_hi    = (addr_reg > rd_hi);
        flags.ins       = (rd_lo >= 16'(EDGE_REACH)) && (addr_reg < (rd_lo - 16'(EDGE_REACH)));
        flags.ext_lo    = (addr_reg < rd_lo);
        flags.hit       = (addr_reg >= rd_lo) && (addr_reg <= rd_hi);
        flags.i1_lt_n   = (i_plus1 < {1'b0, n_reg});
        flags.j_at_i    = (j_reg == i_reg);
        flags.j_at_n    = (j_reg == n_reg);
        flags.mergeable = (({1'b0, cur_hi_reg} + {1'b0, gap_reg}) >= {1'b0, rd_lo});
        flags.out_free  = !out_valid_reg || out_ready;
    end

    // Memory port selection per command.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = i_reg[IW-1:0];
        ram_we    = 1'b0;
        ram_waddr = i_reg[IW-1:0];
        ram_wdata = ram_rdata;
        case (cmd)
            CMD_RD_I:
            begin
                ram_re = 1'b1;
            end
            CMD_RD_I1:
            begin
                ram_re    = 1'b1;
                ram_raddr = i_plus1[IW-1:0];
            end
            CMD_RD_JM1:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_minus1[IW-1:0];
            end
            CMD_RD_JP1:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_plus1[IW-1:0];
            end
            CMD_APP_EXT_HI:
            begin
                ram_we    = 1'b1;
                ram_wdata = {rd_lo, addr_reg};
            end
            CMD_APP_EXT_LO:
            begin
                ram_we    = 1'b1;
                ram_wdata = {addr_reg, rd_hi};
            end
            CMD_APP_NEW:
            begin
                ram_we    = 1'b1;
                ram_waddr = n_reg[IW-1:0];
                ram_wdata = {addr_reg, addr_reg};
            end
            CMD_APP_INS:
            begin
                ram_we    = 1'b1;
                ram_wdata = {addr_reg, addr_reg};
            end
            CMD_WR_J_DEC, CMD_WR_J_INC:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[IW-1:0];
            end
            CMD_MRG_JOIN:
            begin
                ram_we    = 1'b1;
                ram_wdata = {cur_lo_reg, join_hi};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Next values of the counters.
    always_comb
    begin
        n_next = n_reg;
        i_next = i_reg;
        j_next = j_reg;
        case (cmd)
            CMD_START:                 i_next = '0;
            CMD_I_INC, CMD_MRG_ADV:    i_next = i_plus1[CW-1:0];
            CMD_APP_NEW, CMD_APP_INS:  n_next = n_reg + 1'b1;
            CMD_SHIFT_UP_INIT:         j_next = n_reg;
            CMD_WR_J_DEC:              j_next = j_minus1;
            CMD_WR_J_INC:              j_next = j_plus1[CW-1:0];
            CMD_MRG_JOIN:
            begin
                n_next = n_reg - 1'b1;
                j_next = i_plus1[CW-1:0];
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            gap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg <= n_next;
            i_reg <= i_next;
            j_reg <= j_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
            if (cmd == CMD_PUSH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_idx_wide = {{RIDX_W{1'b0}}, res_idx_reg};
    assign count_wide   = {{RCNT_W{1'b0}}, n_reg};

    // Item, working range and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_START:
            begin
                op_reg   <= op_t'(in_op);
                addr_reg <= in_addr;
            end
            CMD_APP_EXT_HI:
            begin
                res_status_reg <= ST_OK;
                res_idx_reg    <= i_reg[IW-1:0];
                res_lo_reg     <= rd_lo;
                res_hi_reg     <= addr_reg;
            end
            CMD_APP_EXT_LO:
            begin
                res_status_reg <= ST_OK;
                res_idx_reg    <= i_reg[IW-1:0];
                res_lo_reg     <= addr_reg;
                res_hi_reg     <= rd_hi;
            end
            CMD_RES_HIT:
            begin
                res_status_reg <= ST_OK;
                res_idx_reg    <= i_reg[IW-1:0];
                res_lo_reg     <= rd_lo;
                res_hi_reg     <= rd_hi;
            end
            CMD_APP_NEW:
            begin
                res_status_reg <= ST_OK;
                res_idx_reg    <= n_reg[IW-1:0];
                res_lo_reg     <= addr_reg;
                res_hi_reg     <= addr_reg;
            end
            CMD_APP_INS:
            begin
                res_status_reg <= ST_OK;
                res_idx_reg    <= i_reg[IW-1:0];
                res_lo_reg     <= addr_reg;
                res_hi_reg     <= addr_reg;
            end
            CMD_RES_FULL, CMD_RES_MISS, CMD_RES_EMPTY:
            begin
                res_status_reg <= (cmd == CMD_RES_FULL) ? ST_FULL :
                                  (cmd == CMD_RES_MISS) ? ST_NOT_FOUND : ST_OK;
                res_idx_reg    <= '0;
                res_lo_reg     <= '0;
                res_hi_reg     <= '0;
            end
            CMD_MRG_LOAD, CMD_MRG_ADV:
            begin
                cur_lo_reg <= rd_lo;
                cur_hi_reg <= rd_hi;
            end
            CMD_MRG_JOIN:
            begin
                cur_hi_reg <= join_hi;
            end
            CMD_PUSH:
            begin
                out_status_reg <= res_status_reg;
                out_index_reg  <= res_idx_wide[RIDX_W-1:0];
                out_start_reg  <= res_lo_reg;
                out_end_reg    <= res_hi_reg;
                out_count_reg  <= count_wide[RCNT_W-1:0];
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_start  = out_start_reg;
    assign out_end    = out_end_reg;
    assign out_count  = out_count_reg;

    // The table never holds more ranges than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_RANGES))
        else $error("range count exceeds table size");

    // The range count moves by at most one per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg == $past(n_reg)) || (n_reg == $past(n_reg) + 1'b1) ||
        (n_reg == $past(n_reg) - 1'b1))
        else $error("range count jumped");

    // The scan index never passes the range count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        i_reg <= n_reg)
        else $error("scan index beyond range count");

endmodule

// ----- src/art_ctrl.sv -----
// Controller state machine of the address range table.
// Depends on art_pkg; sequences art_dp through commands and reads back its flags.
module art_ctrl
    import art_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_flags_t flags,
    output dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_CHK,
        S_A_EVAL,
        S_A_SH_RD,
        S_A_SH_WR,
        S_F_CHK,
        S_F_EVAL,
        S_M_START,
        S_M_LOAD,
        S_M_CHK,
        S_M_EVAL,
        S_M_SH_RD,
        S_M_SH_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_START;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (flags.op)
                    OP_APPEND: state_next = S_A_CHK;
                    OP_FIND:   state_next = S_F_CHK;
                    OP_MERGE:  state_next = S_M_START;
                    default:
                    begin
                        cmd        = CMD_RES_EMPTY;
                        state_next = S_DONE;
                    end
                endcase
            end
            // Append: scan the table in order.
            S_A_CHK:
            begin
                if (!flags.i_at_n)
                begin
                    cmd        = CMD_RD_I;
                    state_next = S_A_EVAL;
                end
                else
                begin
                    cmd        = flags.full ? CMD_RES_FULL : CMD_APP_NEW;
                    state_next = S_DONE;
                end
            end
            S_A_EVAL:
            begin
                if (flags.above)
                begin
                    cmd        = CMD_I_INC;
                    state_next = S_A_CHK;
                end
                else if (flags.ext_hi)
                begin
                    cmd        = CMD_APP_EXT_HI;
                    state_next = S_DONE;
                end
                else if (flags.ins)
                begin
                    if (flags.full)
                    begin
                        cmd        = CMD_RES_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd        = CMD_SHIFT_UP_INIT;
                        state_next = S_A_SH_RD;
                    end
                end
                else if (flags.ext_lo)
                begin
                    cmd        = CMD_APP_EXT_LO;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RES_HIT;
                    state_next = S_DONE;
                end
            end
            // Move entries up by one to open a slot, top entry first.
            S_A_SH_RD:
            begin
                if (flags.j_at_i)
                begin
                    cmd        = CMD_APP_INS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_JM1;
                    state_next = S_A_SH_WR;
                end
            end
            S_A_SH_WR:
            begin
                cmd        = CMD_WR_J_DEC;
                state_next = S_A_SH_RD;
            end
            // Find: first range that holds the address.
            S_F_CHK:
            begin
                if (flags.i_at_n)
                begin
                    cmd        = CMD_RES_MISS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_I;
                    state_next = S_F_EVAL;
                end
            end
            S_F_EVAL:
            begin
                if (flags.hit)
                begin
                    cmd        = CMD_RES_HIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_I_INC;
                    state_next = S_F_CHK;
                end
            end
            // Merge: walk neighbor pairs and join those close enough.
            S_M_START:
            begin
                if (flags.i1_lt_n)
                begin
                    cmd        = CMD_RD_I;
                    state_next = S_M_LOAD;
                end
                else
                begin
                    cmd        = CMD_RES_EMPTY;
                    state_next = S_DONE;
                end
            end
            S_M_LOAD:
            begin
                cmd        = CMD_MRG_LOAD;
                state_next = S_M_CHK;
            end
            S_M_CHK:
            begin
                if (flags.i1_lt_n)
                begin
                    cmd        = CMD_RD_I1;
                    state_next = S_M_EVAL;
                end
                else
                begin
                    cmd        = CMD_RES_EMPTY;
                    state_next = S_DONE;
                end
            end
            S_M_EVAL:
            begin
                if (flags.mergeable)
                begin
                    cmd        = CMD_MRG_JOIN;
                    state_next = S_M_SH_RD;
                end
                else
                begin
                    cmd        = CMD_MRG_ADV;
                    state_next = S_M_CHK;
                end
            end
            // Close the gap left by the absorbed range, bottom entry first.
            S_M_SH_RD:
            begin
                if (flags.j_at_n)
                begin
                    state_next = S_M_CHK;
                end
                else
                begin
                    cmd        = CMD_RD_JP1;
                    state_next = S_M_SH_WR;
                end
            end
            S_M_SH_WR:
            begin
                cmd        = CMD_WR_J_INC;
                state_next = S_M_SH_RD;
            end
            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (flags.out_free)
                begin
                    cmd        = CMD_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Accepting an item makes the controller busy, so items are never taken back to back.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while busy");

    // A result is only handed over when the output register can take it.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUSH) |-> flags.out_free)
        else $error("result pushed into a full output register");

    // Every item ends with a result before the next item is taken.
    a_push_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUSH) |=> in_ready)
        else $error("controller not idle after result");

endmodule
